>>> src/ccs_pkg.sv
// Package for the disc pixel counter: widths, step counts, register codes
// and controller state type. No dependencies.
`timescale 1ns / 1ps

package ccs_pkg;

  localparam int unsigned RadiusBits = 32;
  localparam logic [31:0] RadiusMask = 32'((64'd1 << RadiusBits) - 64'd1);

  localparam int unsigned ProdBits    = 64;
  localparam int unsigned MulSteps    = 32;
  localparam int unsigned MulCntBits  = $clog2(MulSteps);
  localparam int unsigned SqrtSteps   = ProdBits / 2;
  localparam int unsigned SqrtCntBits = $clog2(SqrtSteps);
  localparam int unsigned ModBits     = 34;
  localparam int unsigned ModCntBits  = $clog2(ModBits);
  localparam int unsigned AddrBits    = 3;

  typedef enum logic {
    RegRadius  = 1'b0,
    RegModulus = 1'b1
  } ccs_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSqrt,
    StModSum,
    StModOut,
    StEmit
  } ccs_state_e;

endpackage

>>> src/ccs_if.sv
// Valid/ready channel interfaces for column items and pixel count items.
// Depends on nothing.
`timescale 1ns / 1ps

interface ccs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] column;
  logic        last;

  modport source (output valid, output column, output last, input ready);
  modport sink   (input valid, input column, input last, output ready);
endinterface

interface ccs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_count;

  modport source (output valid, output pixel_count, input ready);
  modport sink   (input valid, input pixel_count, output ready);
endinterface

>>> src/ccs_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [32:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [ccs_pkg::MulCntBits-1:0] cnt_q;
  logic [32:0]                    hi_q, hi_d;
  logic [31:0]                    lo_q, lo_d;
  logic [32:0]                    b_q;
  logic [33:0]                    psum;

  always_comb begin
    psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : 34'd0);
    hi_d = psum[33:1];
    lo_d = {psum[0], lo_q[31:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ccs_pkg::MulCntBits'(ccs_pkg::MulSteps - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= a_i;
      b_q  <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  // product is below 2^64, so the top bit of the high half stays clear
  assign prod_o = {hi_q[31:0], lo_q};

endmodule

>>> src/ccs_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o,
  output logic        exact_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [ccs_pkg::SqrtCntBits-1:0] cnt_q;
  logic [63:0]                     rad_q;
  logic [32:0]                     rem_q, rem_d;
  logic [31:0]                     root_q, root_d;
  logic [34:0]                     rem_sh;
  logic [34:0]                     trial;
  logic [34:0]                     diff;
  logic                            ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    rem_d  = ge ? diff[32:0] : rem_sh[32:0];
    root_d = {root_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ccs_pkg::SqrtCntBits'(ccs_pkg::SqrtSteps - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o  = done_q;
  assign root_o  = root_q;
  assign exact_o = (rem_q == '0);

endmodule

>>> src/ccs_mod.sv
// Bit-serial modulo reduction of a 34-bit value, one bit per cycle.
// A zero modulus leaves the low 32 bits. Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ccs_pkg::ModBits-1:0] value_i,
  input  logic [31:0]                 modulus_i,
  output logic                        done_o,
  output logic [31:0]                 rem_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [ccs_pkg::ModCntBits-1:0] cnt_q;
  logic [ccs_pkg::ModBits-1:0]    val_q;
  logic [31:0]                    rem_q, rem_d;
  logic [32:0]                    rem_sh;
  logic [32:0]                    diff;

  always_comb begin
    rem_sh = {rem_q, val_q[ccs_pkg::ModBits-1]};
    diff   = rem_sh - {1'b0, modulus_i};
    rem_d  = (rem_sh >= {1'b0, modulus_i}) ? diff[31:0] : rem_sh[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ccs_pkg::ModCntBits'(ccs_pkg::ModBits - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      rem_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[ccs_pkg::ModBits-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> src/circle_column_height_sum.sv
// Top level of the disc pixel counter: APB registers, sequencer, running sum
// and output register. Depends on ccs_pkg, ccs_if, ccs_mul, ccs_sqrt, ccs_mod.
`timescale 1ns / 1ps

// Channel   Dir  Payload                    Handshake
// in_i      in   column[31:0], last         valid/ready, taken when both high
// out_o     out  pixel_count[31:0]          valid/ready, taken when both high
// APB       in   paddr[2:0], pwdata[31:0]   write when psel&penable&pwrite
//
// One item at a time: the accept, a multiply, a square root (two radicand
// bits per step) and a modulo pass, joined by handoffs, all finish before
// the next accept. A last item adds a modulo pass for 4*sum, a handoff and
// an output load once the output register is free.
// Reset clears the sum, sets radius and modulus to 1, and empties the output.
// A stalled output holds back only a waiting count; no columns are taken until it loads.

module circle_column_height_sum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ccs_in_if.sink                       in_i,
  ccs_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ccs_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  ccs_pkg::ccs_state_e state_q, state_d;

  logic [31:0] radius_q, modulus_q;
  logic [31:0] sum_q, sum_d;
  logic        last_q;
  logic        out_valid_q;
  logic [31:0] pixel_q;

  logic        in_take;
  logic        cfg_wr;
  logic        out_load;
  logic [31:0] rad_eff;
  logic [32:0] col_diff;
  logic [31:0] mul_a;
  logic [32:0] mul_b;

  logic        mul_done;
  logic [63:0] mul_prod;
  logic        sqrt_start;
  logic        sqrt_done;
  logic [31:0] sqrt_root;
  logic        sqrt_exact;
  logic        mod_start;
  logic        mod_done;
  logic [ccs_pkg::ModBits-1:0] mod_value;
  logic [31:0] mod_rem;
  logic [32:0] sum_plus_h;

  // Configuration port: the register index is the word address bit.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (ccs_pkg::ccs_reg_e'(paddr[2]) == ccs_pkg::RegModulus) ? modulus_q
                                                                        : radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 32'd1;
      modulus_q <= 32'd1;
    end else if (cfg_wr) begin
      case (ccs_pkg::ccs_reg_e'(paddr[2]))
        ccs_pkg::RegRadius:  radius_q  <= pwdata;
        ccs_pkg::RegModulus: modulus_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Radicand r^2 - x^2 = (r - x)(r + x); a column at or past the radius
  // feeds a zero multiplier so its height comes out zero.
  assign in_i.ready = (state_q == ccs_pkg::StIdle);
  assign in_take    = in_i.valid && in_i.ready;
  assign rad_eff    = radius_q & ccs_pkg::RadiusMask;
  assign col_diff   = {1'b0, rad_eff} - {1'b0, in_i.column};
  assign mul_a      = col_diff[32] ? 32'd0 : col_diff[31:0];
  assign mul_b      = {1'b0, rad_eff} + {1'b0, in_i.column};

  // Ceiling root folds in as a carry: height = floor root + (remainder != 0).
  assign sum_plus_h = {1'b0, sum_q} + {1'b0, sqrt_root} + {32'd0, ~sqrt_exact};

  ccs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_take),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ccs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (mul_prod),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root),
    .exact_o (sqrt_exact)
  );

  ccs_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .value_i   (mod_value),
    .modulus_i (modulus_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  // Sequencer: hand each unit's result to the next, then reduce 4*sum on
  // a last item and park it until the output register is free.
  always_comb begin
    state_d    = state_q;
    sum_d      = sum_q;
    sqrt_start = 1'b0;
    mod_start  = 1'b0;
    mod_value  = {1'b0, sum_plus_h};
    out_load   = 1'b0;
    case (state_q)
      ccs_pkg::StIdle: begin
        if (in_take) state_d = ccs_pkg::StMul;
      end
      ccs_pkg::StMul: begin
        if (mul_done) begin
          sqrt_start = 1'b1;
          state_d    = ccs_pkg::StSqrt;
        end
      end
      ccs_pkg::StSqrt: begin
        if (sqrt_done) begin
          mod_start = 1'b1;
          state_d   = ccs_pkg::StModSum;
        end
      end
      ccs_pkg::StModSum: begin
        if (mod_done) begin
          sum_d = mod_rem;
          if (last_q) begin
            mod_start = 1'b1;
            mod_value = {mod_rem, 2'b00};
            state_d   = ccs_pkg::StModOut;
          end else begin
            state_d = ccs_pkg::StIdle;
          end
        end
      end
      ccs_pkg::StModOut: begin
        if (mod_done) state_d = ccs_pkg::StEmit;
      end
      ccs_pkg::StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          sum_d    = 32'd0;
          state_d  = ccs_pkg::StIdle;
        end
      end
      default: state_d = ccs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccs_pkg::StIdle;
      sum_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the last flag of the item in flight and the count.
  always_ff @(posedge clk_i) begin
    if (in_take) last_q <= in_i.last;
    if (out_load) pixel_q <= mod_rem;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_count = pixel_q;

endmodule

>>> src/ccs_checker.sv
// Port-level checker for the disc pixel counter, bound to the top level.
// Depends on circle_column_height_sum and its ports only.
`timescale 1ns / 1ps

module ccs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_count,
  input logic        pready
);

  // An accepted item keeps the input closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open right after an item was taken");

  // A new count is only loaded while the input is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("count appeared while the input was open");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel_count)))
    else $error("stalled count dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind circle_column_height_sum ccs_checker u_ccs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_pixel_count (out_o.pixel_count),
  .pready          (pready)
);

>>> tb/tb_circle_column_height_sum.sv
// Testbench for circle_column_height_sum: streams column items, predicts each
// pixel count and checks it. Depends on ccs_pkg, ccs_if and the block's RTL.
`timescale 1ns / 1ps

module tb_circle_column_height_sum;

  // Generous bound for about 1100 items, plus drains.
  localparam int unsigned CycleLimit  = 1500000;
  // Settle time once everything is taken and answered.
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned HoldCycles  = 1500;
  localparam int unsigned RandomItems = 1050;

  typedef struct {
    logic [31:0] column;
    logic        last;
  } column_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ccs_pkg::AddrBits-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ccs_in_if  col_if ();
  ccs_out_if cnt_if ();

  circle_column_height_sum u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (col_if),
    .out_o  (cnt_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Columns waiting to be offered, and pixel counts still owed by the block.
  column_item_t column_q[$];
  logic [31:0]  pixel_count_q[$];

  // Local copy of the register file and the running height sum.
  logic [31:0] cfg_radius  = 32'd1;
  logic [31:0] cfg_modulus = 32'd1;
  logic [31:0] height_acc  = 32'd0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          send_idle_en   = 1'b1;
  bit          recv_idle_en   = 1'b1;
  int unsigned send_gap       = 0;
  int unsigned recv_stall     = 0;
  bit          hold_arm       = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned hold_left      = 0;

  // Exact ceiling square root of a 64-bit radicand, two bits per step.
  function automatic logic [63:0] root_ceil(input logic [63:0] radicand);
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] pair;
    rest = radicand;
    root = '0;
    pair = 64'h4000_0000_0000_0000;
    while (pair > rest) pair = pair >> 2;
    while (pair != 0) begin
      if (rest >= root + pair) begin
        rest = rest - (root + pair);
        root = (root >> 1) + pair;
      end else begin
        root = root >> 1;
      end
      pair = pair >> 2;
    end
    if (root * root < radicand) root = root + 64'd1;
    return root;
  endfunction

  // Reduce by the modulus; a zero modulus just wraps at 32 bits.
  function automatic logic [31:0] fold(input logic [63:0] value);
    if (cfg_modulus == 32'd0) return value[31:0];
    return 32'(value % {32'd0, cfg_modulus});
  endfunction

  function automatic logic [31:0] column_height(input logic [31:0] column);
    logic [63:0] r;
    logic [63:0] x;
    r = {32'd0, cfg_radius & ccs_pkg::RadiusMask};
    x = {32'd0, column};
    if (x >= r) return 32'd0;
    return 32'(root_ceil(r * r - x * x));
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long gap.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Fold one accepted column into the sum; a last column owes a count.
  task automatic absorb_column(input logic [31:0] column, input logic last);
    height_acc = fold({32'd0, height_acc} + {32'd0, column_height(column)});
    if (last) begin
      pixel_count_q.push_back(fold({30'd0, height_acc, 2'b00}));
      height_acc = 32'd0;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Column driver: hold an offered item until it is taken, then advance.
  always @(posedge clk_i) begin : drive_columns
    logic taken;
    if (!rst_ni) begin
      col_if.valid <= 1'b0;
    end else begin
      taken = col_if.valid && col_if.ready;
      if (taken) begin
        absorb_column(col_if.column, col_if.last);
        void'(column_q.pop_front());
        send_gap = send_idle_en ? pick_gap() : 0;
      end
      if (col_if.valid && !taken) begin
        // hold the current item
      end else if (send_gap != 0) begin
        send_gap--;
        col_if.valid <= 1'b0;
      end else if (column_q.size() != 0) begin
        col_if.valid  <= 1'b1;
        col_if.column <= column_q[0].column;
        col_if.last   <= column_q[0].last;
      end else begin
        col_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing into it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Count monitor: compare each taken count with the oldest prediction.
  always @(posedge clk_i) begin : check_counts
    logic [31:0] want;
    if (!rst_ni) begin
      cnt_if.ready <= 1'b0;
    end else begin
      if (cnt_if.valid && cnt_if.ready) begin
        if (pixel_count_q.size() == 0) begin
          $display("%0t: pixel count with none expected: expected none, actual %0d",
                   $time, cnt_if.pixel_count);
          mismatch_count++;
        end else begin
          want = pixel_count_q.pop_front();
          if (cnt_if.pixel_count !== want) begin
            $display("%0t: pixel_count: expected %0d, actual %0d",
                     $time, want, cnt_if.pixel_count);
            mismatch_count++;
          end
        end
        recv_stall = pick_gap();
      end else if (cnt_if.ready && recv_stall == 0 && $urandom_range(0, 15) == 0) begin
        recv_stall = pick_gap();
      end
      if (!recv_idle_en) recv_stall = 0;
      if (hold_left != 0 || recv_stall != 0) begin
        cnt_if.ready <= 1'b0;
        if (recv_stall != 0) recv_stall--;
      end else begin
        cnt_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("circle_column_height_sum: mismatch");
      $finish;
    end
  end

  // Register write with a setup and an access phase; the block latches it when pready is seen high.
  task automatic write_reg(input ccs_pkg::ccs_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ccs_pkg::RegRadius) cfg_radius = value;
    else cfg_modulus = value;
  endtask

  task automatic set_disc(input logic [31:0] radius, input logic [31:0] modulus);
    write_reg(ccs_pkg::RegRadius, radius);
    write_reg(ccs_pkg::RegModulus, modulus);
  endtask

  task automatic queue_column(input logic [31:0] column, input logic last);
    column_item_t item;
    item.column = column;
    item.last   = last;
    column_q.push_back(item);
  endtask

  // Wait until everything is taken and answered, then let the pipe settle.
  task automatic drain();
    while (column_q.size() != 0 || col_if.valid || pixel_count_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(1, 8);
      4, 5:    return $urandom_range(9, 1000);
      6:       return $urandom_range(1, 65535);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom_range(2, 100);
      default: return $urandom();
    endcase
  endfunction

  // Column drawn inside the disc where there is one.
  function automatic logic [31:0] inner_column();
    if (cfg_radius == 32'd0) return $urandom();
    return $urandom() % cfg_radius;
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_no;
    int unsigned target;
    int unsigned queued;
    int unsigned run_len;
    bit          sweep;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    col_if.valid  = 1'b0;
    col_if.column = '0;
    col_if.last   = 1'b0;
    cnt_if.ready  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: radius 1, modulus 1, so every count folds to zero.
    queue_column(32'd0, 1'b1);
    drain();

    // Small disc, no reduction: whole quarter plus columns on and past the edge.
    set_disc(32'd5, 32'd0);
    queue_column(32'd0, 1'b0);
    queue_column(32'd1, 1'b0);
    queue_column(32'd2, 1'b0);
    queue_column(32'd3, 1'b0);
    queue_column(32'd5, 1'b0);
    queue_column(32'hFFFF_FFFF, 1'b0);
    queue_column(32'd4, 1'b1);
    drain();

    // Zero radius: all heights vanish.
    set_disc(32'd0, 32'd7);
    queue_column(32'd0, 1'b0);
    queue_column(32'hFFFF_FFFF, 1'b1);
    drain();

    // Largest disc with the largest modulus, columns at both ends.
    set_disc(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_column(32'd0, 1'b0);
    queue_column(32'h8000_0000, 1'b0);
    queue_column(32'hFFFF_FFFE, 1'b0);
    queue_column(32'hFFFF_FFFF, 1'b1);
    drain();

    // Largest disc, no reduction: the sum wraps at 32 bits.
    set_disc(32'hFFFF_FFFF, 32'd0);
    queue_column(32'd0, 1'b0);
    queue_column(32'd0, 1'b0);
    queue_column(32'd12345, 1'b0);
    queue_column(32'd0, 1'b1);
    drain();

    // Random phases of mostly well-formed runs with some noise.
    sent     = 0;
    phase_no = 0;
    while (sent < RandomItems) begin
      set_disc(pick_radius(), pick_modulus());
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      if (phase_no == 1) begin
        // stream without gaps into a long receiver stall
        if (cfg_radius == 32'd0) set_disc(32'd300, 32'd1000);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        hold_arm    <= 1'b1;
      end
      target = $urandom_range(20, 60);
      queued = 0;
      while (queued < target) begin
        case ($urandom_range(0, 9))
          0: begin
            // noise
            queue_column($urandom(), 1'($urandom_range(0, 1)));
            queued++;
          end
          1: begin
            // broken run: no last, so it runs into the next one
            run_len = $urandom_range(1, 4);
            repeat (run_len) queue_column(inner_column(), 1'b0);
            queued += run_len;
          end
          default: begin
            sweep = (cfg_radius != 0 && cfg_radius <= 8 && $urandom_range(0, 1) == 1);
            run_len = sweep ? cfg_radius : $urandom_range(1, 8);
            for (int unsigned k = 0; k < run_len; k++)
              queue_column(sweep ? k : inner_column(), k == run_len - 1);
            queued += run_len;
          end
        endcase
      end
      // close the phase so no partial sum spans a register write
      queue_column(inner_column(), 1'b1);
      queued++;
      sent += queued;
      phase_no++;
      drain();
    end

    if (mismatch_count == 0) begin
      $display("circle_column_height_sum: match");
    end else begin
      $display("circle_column_height_sum: mismatch");
    end
    $finish;
  end

endmodule
